/* rtl/plvt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pending I/O latency tracker package
// Table geometry, field widths, action codes, divider constants and the
// shared types of the tracker.
// ----------------------------------------------------------------------------
package plvt_pkg;

  localparam int unsigned TABLE_BITS = 11;
  localparam int unsigned WAYS       = 4;
  localparam int unsigned BUCKETS    = 1 << TABLE_BITS;

  localparam int unsigned ACTION_W   = 32;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned OUTCOME_W  = 3;
  localparam int unsigned CNT_W      = 14;
  localparam int unsigned SEC_W      = 35;

  localparam int unsigned CODE_W     = 16;
  localparam int unsigned NOTIFY_POS = 26;
  localparam logic [CODE_W-1:0] CODE_ISSUE    = CODE_W'(7);
  localparam logic [CODE_W-1:0] CODE_COMPLETE = CODE_W'(8);

  localparam int unsigned HASH_S1 = 18;
  localparam int unsigned HASH_S2 = 51;
  localparam int unsigned HASH_S3 = 54;
  localparam int unsigned HASH_S4 = 57;
  localparam int unsigned HASH_S5 = 61;
  localparam int unsigned HASH_S6 = 63;

  localparam longint unsigned NS_PER_SEC = 64'd1000000000;
  localparam int unsigned DIV_SHIFT    = 9;
  localparam int unsigned DIV_ODD_W    = 21;
  localparam logic [DIV_ODD_W-1:0] DIV_ODD = DIV_ODD_W'(NS_PER_SEC >> DIV_SHIFT);
  localparam int unsigned MUL_W        = 32;
  localparam int unsigned MUL_STEPS    = 4;
  localparam int unsigned RECIP_SHIFT  = TIME_W - DIV_SHIFT + DIV_ODD_W;
  localparam int unsigned RECIP_CALC_W = RECIP_SHIFT + 1;
  localparam logic [RECIP_CALC_W-1:0] RECIP_CALC =
    ((RECIP_CALC_W'(1) << RECIP_SHIFT) + RECIP_CALC_W'(DIV_ODD) - RECIP_CALC_W'(1)) /
    RECIP_CALC_W'(DIV_ODD);
  localparam logic [2*MUL_W-1:0] RECIP = RECIP_CALC[2*MUL_W-1:0];
  localparam int unsigned ACC_W        = RECIP_SHIFT + SEC_W;
  localparam int unsigned DIV_CNT_W    = $clog2(MUL_STEPS + 1);

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_IGNORED   = 3'd0,
    OUT_STORED    = 3'd1,
    OUT_DUPLICATE = 3'd2,
    OUT_FULL      = 3'd3,
    OUT_MATCHED   = 3'd4,
    OUT_UNMATCHED = 3'd5
  } outcome_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_MODIFY,
    ST_LATENCY,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]  sector;
    logic [TIME_W-1:0] dispatch;
  } slot_t;

  typedef logic  [WAYS-1:0] way_vec_t;
  typedef slot_t [WAYS-1:0] slot_row_t;

endpackage

/* rtl/plvt_evt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace event channel
// Valid/ready channel carrying one trace event word.
// ----------------------------------------------------------------------------
interface plvt_evt_if import plvt_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action_word;
  logic [KEY_W-1:0]    sector;
  logic [TIME_W-1:0]   event_time;

  modport source (output valid, output action_word, output sector, output event_time,
                  input ready);
  modport sink   (input valid, input action_word, input sector, input event_time,
                  output ready);

endinterface

/* rtl/plvt_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker result channel
// Valid/ready channel carrying one result word per trace event.
// ----------------------------------------------------------------------------
interface plvt_res_if import plvt_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [TIME_W-1:0]    latency_ns;
  logic                 latency_valid;
  logic [CNT_W-1:0]     in_flight;
  logic [SEC_W-1:0]     second_index;

  modport source (output valid, output outcome, output latency_ns, output latency_valid,
                  output in_flight, output second_index, input ready);
  modport sink   (input valid, input outcome, input latency_ns, input latency_valid,
                  input in_flight, input second_index, output ready);

endinterface

/* rtl/plvt_sec_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seconds divider
// Divides a nanosecond time by one billion: drops the factor 2^9 by a shift,
// then multiplies by the scaled reciprocal of 1953125, one 32 by 32 partial
// product a cycle, and keeps the top bits of the product.
// ----------------------------------------------------------------------------
module plvt_sec_div import plvt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TIME_W-1:0] time_i,
  output logic              done_o,
  output logic [SEC_W-1:0]  quot_o
);

  logic [TIME_W-1:0]    num_q;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [2*MUL_W-1:0]   mul_p;
  logic [ACC_W-1:0]     addend;

  always_comb begin
    mul_a = cnt_q[1] ? num_q[TIME_W-1:MUL_W] : num_q[MUL_W-1:0];
    mul_b = cnt_q[0] ? RECIP[2*MUL_W-1:MUL_W] : RECIP[MUL_W-1:0];
    mul_p = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);
    case (cnt_q[1:0]) inside
      2'd0:       addend = ACC_W'(mul_p);
      2'd1, 2'd2: addend = ACC_W'(mul_p) << MUL_W;
      default:    addend = ACC_W'(mul_p) << (2*MUL_W);
    endcase
    acc_d = acc_q + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= DIV_CNT_W'(MUL_STEPS);
    end else if (start_i) begin
      cnt_q <= '0;
    end else if (!done_o) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= time_i >> DIV_SHIFT;
      acc_q <= '0;
    end else if (!done_o) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = (cnt_q == DIV_CNT_W'(MUL_STEPS));
  assign quot_o = acc_q[RECIP_SHIFT +: SEC_W];

endmodule

/* rtl/pending_io_latency_tracker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pending I/O latency tracker
// Hashed table of outstanding requests: issue events store sector and
// dispatch time, completion events free the entry and give the latency.
// ----------------------------------------------------------------------------
// After reset the block sweeps the valid memory, one bucket a cycle, over all
// 2048 buckets (2^TABLE_BITS) and takes no event until the sweep is done.
// Events are then handled one at a time, and the block is ready for the next
// event in the cycle after the result is loaded. The bucket hash, read,
// compare/write-back and latency subtract run in that order; the seconds
// divider, a reciprocal multiply built from four 32 by 32 partial products,
// runs alongside them, and the result is then loaded in the wait state. A
// result waiting in the output register does not stop the next event from
// being accepted.
module pending_io_latency_tracker_unit import plvt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  plvt_evt_if.sink  evt_i,
  plvt_res_if.source res_o
);

  state_e state_q, state_d;
  logic [TABLE_BITS-1:0] clr_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  out_valid_q;

  logic [KEY_W-1:0]      sector_q;
  logic [TIME_W-1:0]     time_q;
  logic                  act_q;
  logic                  issue_q;
  logic [KEY_W-1:0]      hash_a_q;
  logic [TABLE_BITS-1:0] bucket_q, bucket_d;
  logic [TIME_W-1:0]     disp_q;
  outcome_e              outcome_q, outcome_d;
  logic [TIME_W-1:0]     lat_q, lat_d;
  logic                  lat_ok_q, lat_ok_d;

  logic [OUTCOME_W-1:0]  out_outcome_q;
  logic [TIME_W-1:0]     out_lat_q;
  logic                  out_lat_ok_q;
  logic [CNT_W-1:0]      out_cnt_q;
  logic [SEC_W-1:0]      out_sec_q;

  way_vec_t  vld_mem [BUCKETS];
  slot_row_t slot_mem [BUCKETS];
  way_vec_t  vld_rd_q;
  slot_row_t slot_rd_q;

  logic                  evt_accept;
  logic                  evt_act;
  logic                  out_load;
  logic                  div_done;
  logic [SEC_W-1:0]      div_quot;
  logic [KEY_W-1:0]      hash_a_d;
  logic [KEY_W-1:0]      hash_h;
  logic                  mem_re;
  logic                  vld_we;
  logic [TABLE_BITS-1:0] vld_waddr;
  way_vec_t              vld_wdata;
  logic                  slot_we;
  slot_row_t             slot_wrow;
  way_vec_t              hit_vec, hit_oh, free_oh;
  logic [TIME_W-1:0]     sel_disp;
  logic [TIME_W:0]       lat_diff;

  plvt_sec_div u_sec_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(evt_accept),
    .time_i (evt_i.event_time),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign evt_i.ready = (state_q == ST_IDLE);
  assign evt_accept  = evt_i.valid && evt_i.ready;
  assign evt_act     = !evt_i.action_word[NOTIFY_POS] &&
                       ((evt_i.action_word[CODE_W-1:0] == CODE_ISSUE) ||
                        (evt_i.action_word[CODE_W-1:0] == CODE_COMPLETE));
  assign out_load    = (state_q == ST_WAIT) && div_done && (!out_valid_q || res_o.ready);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:   if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE:    if (evt_accept) state_d = ST_HASH;
      ST_HASH:    state_d = act_q ? ST_READ : ST_WAIT;
      ST_READ:    state_d = ST_MODIFY;
      ST_MODIFY:  state_d = ST_LATENCY;
      ST_LATENCY: state_d = ST_WAIT;
      ST_WAIT:    if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Hash, bucket access and table update
  always_comb begin
    hash_a_d = sector_q - (sector_q << HASH_S1) - (sector_q << HASH_S2)
             + (sector_q << HASH_S3);
    hash_h   = hash_a_q - (sector_q << HASH_S4) + (sector_q << HASH_S5)
             + (sector_q << HASH_S6);
    bucket_d = hash_h[KEY_W-1 -: TABLE_BITS];
    mem_re   = (state_q == ST_READ);

    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = vld_rd_q[w] && (slot_rd_q[w].sector == sector_q);
    end
    hit_oh  = hit_vec & (~hit_vec + way_vec_t'(1));
    free_oh = ~vld_rd_q & (vld_rd_q + way_vec_t'(1));

    sel_disp = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_oh[w]) sel_disp = sel_disp | slot_rd_q[w].dispatch;
      slot_wrow[w] = free_oh[w] ? slot_t'{sector: sector_q, dispatch: time_q} : slot_rd_q[w];
    end

    outcome_d = outcome_q;
    cnt_d     = cnt_q;
    vld_we    = 1'b0;
    vld_wdata = vld_rd_q;
    slot_we   = 1'b0;
    vld_waddr = bucket_q;
    if (state_q == ST_CLEAR) begin
      vld_we    = 1'b1;
      vld_waddr = clr_q;
      vld_wdata = '0;
    end else if (state_q == ST_MODIFY) begin
      if (issue_q) begin
        if (|hit_vec) begin
          outcome_d = OUT_DUPLICATE;
        end else if (|free_oh) begin
          outcome_d = OUT_STORED;
          vld_we    = 1'b1;
          vld_wdata = vld_rd_q | free_oh;
          slot_we   = 1'b1;
          if (cnt_q != '1) cnt_d = cnt_q + CNT_W'(1);
        end else begin
          outcome_d = OUT_FULL;
        end
      end else begin
        if (|hit_vec) begin
          outcome_d = OUT_MATCHED;
          vld_we    = 1'b1;
          vld_wdata = vld_rd_q & ~hit_oh;
          if (cnt_q != '0) cnt_d = cnt_q - CNT_W'(1);
        end else begin
          outcome_d = OUT_UNMATCHED;
        end
      end
    end

    lat_diff = {1'b0, time_q} - {1'b0, disp_q};
    lat_ok_d = (outcome_q == OUT_MATCHED) && !lat_diff[TIME_W];
    lat_d    = lat_ok_d ? lat_diff[TIME_W-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (vld_we) vld_mem[vld_waddr] <= vld_wdata;
    if (mem_re) vld_rd_q <= vld_mem[bucket_d];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[bucket_q] <= slot_wrow;
    if (mem_re) slot_rd_q <= slot_mem[bucket_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + TABLE_BITS'(1);
      if (state_q == ST_MODIFY) cnt_q <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_accept) begin
      sector_q <= evt_i.sector;
      time_q   <= evt_i.event_time;
      act_q    <= evt_act;
      issue_q  <= (evt_i.action_word[CODE_W-1:0] == CODE_ISSUE);
    end
    if (state_q == ST_HASH) begin
      hash_a_q  <= hash_a_d;
      outcome_q <= OUT_IGNORED;
      lat_q     <= '0;
      lat_ok_q  <= 1'b0;
    end
    if (state_q == ST_READ) bucket_q <= bucket_d;
    if (state_q == ST_MODIFY) begin
      outcome_q <= outcome_d;
      disp_q    <= sel_disp;
    end
    if (state_q == ST_LATENCY) begin
      lat_q    <= lat_d;
      lat_ok_q <= lat_ok_d;
    end
    if (out_load) begin
      out_outcome_q <= outcome_q;
      out_lat_q     <= lat_q;
      out_lat_ok_q  <= lat_ok_q;
      out_cnt_q     <= cnt_q;
      out_sec_q     <= div_quot;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.outcome       = out_outcome_q;
  assign res_o.latency_ns    = out_lat_q;
  assign res_o.latency_valid = out_lat_ok_q;
  assign res_o.in_flight     = out_cnt_q;
  assign res_o.second_index  = out_sec_q;

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MODIFY) |-> $onehot0(hit_vec))
    else $error("sector held in more than one way of its bucket");

  a_store_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MODIFY && outcome_d == OUT_STORED) |->
      ($countones(vld_wdata) == $countones(vld_rd_q) + 1))
    else $error("stored issue did not claim exactly one way");

  a_free_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MODIFY && outcome_d == OUT_MATCHED) |->
      ($countones(vld_wdata) + 1 == $countones(vld_rd_q)))
    else $error("matched completion did not free exactly one way");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MODIFY && (outcome_d == OUT_DUPLICATE || outcome_d == OUT_FULL ||
                              outcome_d == OUT_UNMATCHED)) |=> $stable(cnt_q))
    else $error("in-flight count moved without a table change");

  a_cnt_only_modify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_MODIFY) |=> $stable(cnt_q))
    else $error("in-flight count moved outside the update cycle");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pending I/O latency tracker testbench
// Feeds trace words (issues, completions, notify and foreign actions) through
// the event channel with bursty gaps. It keeps its own model of the hashed
// request table and checks every result word, field by field, in order,
// while the result side stalls on a changing pattern.
// ----------------------------------------------------------------------------
module testbench;
  import plvt_pkg::*;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    sector;
    logic [TIME_W-1:0]   stamp;
  } trace_word_t;

  typedef struct packed {
    outcome_e            outcome;
    logic [TIME_W-1:0]   latency_ns;
    logic                latency_valid;
    logic [CNT_W-1:0]    in_flight;
    logic [SEC_W-1:0]    second_index;
  } tracker_reply_t;

  localparam int unsigned SLOTS = BUCKETS * WAYS;
  localparam logic [ACTION_W-1:0] NOTIFY_MASK = ACTION_W'(1) << NOTIFY_POS;
  localparam logic [ACTION_W-1:0] HIGH_BITS = 32'hFFFF_0000 & ~NOTIFY_MASK;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                drv_valid  = 1'b0;
  logic [ACTION_W-1:0] drv_action = '0;
  logic [KEY_W-1:0]    drv_sector = '0;
  logic [TIME_W-1:0]   drv_stamp  = '0;
  logic                sink_ready = 1'b0;

  plvt_evt_if evt ();
  plvt_res_if res ();

  assign evt.valid       = drv_valid;
  assign evt.action_word = drv_action;
  assign evt.sector      = drv_sector;
  assign evt.event_time  = drv_stamp;
  assign res.ready       = sink_ready;

  pending_io_latency_tracker_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt.sink),
    .res_o  (res.source)
  );

  always #2 clk_i = ~clk_i;

  // request table model
  bit               held_valid    [SLOTS];
  logic [KEY_W-1:0] held_sector   [SLOTS];
  logic [TIME_W-1:0] held_dispatch [SLOTS];
  logic [CNT_W-1:0] flight_count = '0;

  trace_word_t    trace_backlog[$];
  tracker_reply_t replies_due[$];
  logic [KEY_W-1:0] crowd[$];
  logic [KEY_W-1:0] open_sectors[$];
  logic [TIME_W-1:0] clock_ns;

  int unsigned outcome_tally [6];
  int unsigned early_cnt    = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned reply_cnt    = 0;
  int unsigned useful_cnt   = 0;

  function automatic logic [TABLE_BITS-1:0] bucket_hash(logic [KEY_W-1:0] key);
    logic [63:0] h;
    logic [63:0] n;
    h = key;
    n = key;
    n = n << 18; h = h - n;
    n = n << 33; h = h - n;
    n = n << 3;  h = h + n;
    n = n << 3;  h = h - n;
    n = n << 4;  h = h + n;
    n = n << 2;  h = h + n;
    return h[63 -: TABLE_BITS];
  endfunction

  task automatic update_request_table(input trace_word_t tw);
    logic [CODE_W-1:0] code;
    int             base;
    int             hit;
    tracker_reply_t rep;
    code = tw.action[CODE_W-1:0];
    rep.outcome       = OUT_IGNORED;
    rep.latency_ns    = '0;
    rep.latency_valid = 1'b0;
    hit = -1;
    if (!tw.action[NOTIFY_POS] && (code == CODE_ISSUE || code == CODE_COMPLETE)) begin
      base = int'(bucket_hash(tw.sector)) * WAYS;
      for (int w = 0; w < WAYS; w++) begin
        if (hit < 0 && held_valid[base + w] && held_sector[base + w] == tw.sector) begin
          hit = base + w;
        end
      end
      if (code == CODE_ISSUE) begin
        if (hit >= 0) begin
          rep.outcome = OUT_DUPLICATE;
        end else begin
          rep.outcome = OUT_FULL;
          for (int w = 0; w < WAYS; w++) begin
            if (rep.outcome == OUT_FULL && !held_valid[base + w]) begin
              held_valid[base + w]    = 1'b1;
              held_sector[base + w]   = tw.sector;
              held_dispatch[base + w] = tw.stamp;
              if (flight_count != {CNT_W{1'b1}}) flight_count = flight_count + CNT_W'(1);
              rep.outcome = OUT_STORED;
            end
          end
        end
      end else if (hit >= 0) begin
        rep.outcome = OUT_MATCHED;
        if (flight_count != '0) flight_count = flight_count - CNT_W'(1);
        if (tw.stamp >= held_dispatch[hit]) begin
          rep.latency_ns    = tw.stamp - held_dispatch[hit];
          rep.latency_valid = 1'b1;
        end
        held_valid[hit] = 1'b0;
      end else begin
        rep.outcome = OUT_UNMATCHED;
      end
    end
    rep.in_flight    = flight_count;
    rep.second_index = SEC_W'(tw.stamp / NS_PER_SEC);
    replies_due.push_back(rep);
  endtask

  function automatic void queue_word(logic [ACTION_W-1:0] a, logic [KEY_W-1:0] s,
                                     logic [TIME_W-1:0] t);
    trace_word_t tw;
    tw.action = a;
    tw.sector = s;
    tw.stamp  = t;
    trace_backlog.push_back(tw);
  endfunction

  function automatic void gather_same_bucket(logic [TABLE_BITS-1:0] b, int n);
    logic [KEY_W-1:0] k;
    int found;
    found = 0;
    while (found < n) begin
      k = {$urandom, $urandom};
      if (bucket_hash(k) == b) begin
        crowd.push_back(k);
        found++;
      end
    end
  endfunction

  function automatic logic [ACTION_W-1:0] valid_action(logic [CODE_W-1:0] code);
    return ($urandom & ~NOTIFY_MASK & 32'hFFFF_0000) | ACTION_W'(code);
  endfunction

  function automatic logic [TIME_W-1:0] next_stamp();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      clock_ns = clock_ns + $urandom_range(1, 3000000);
      return clock_ns;
    end else if (r < 90) begin
      return {$urandom, $urandom};
    end
    return clock_ns - $urandom_range(0, 1000);
  endfunction

  // sender: bursts of random length with random gaps
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;
  trace_word_t next_word;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && evt.ready) begin
        next_word.action = drv_action;
        next_word.sector = drv_sector;
        next_word.stamp  = drv_stamp;
        update_request_table(next_word);
      end
      if (!drv_valid || evt.ready) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          drv_valid <= 1'b0;
        end else if (trace_backlog.size() != 0) begin
          next_word = trace_backlog.pop_front();
          drv_action <= next_word.action;
          drv_sector <= next_word.sector;
          drv_stamp  <= next_word.stamp;
          drv_valid  <= 1'b1;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
            gap_left   = $urandom_range(0, 12);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stalls on a rotating pattern that changes from phase to phase
  logic [15:0]  stall_pat  = 16'hFFFF;
  logic [1:0]   ready_mode = '0;
  int unsigned  ready_left = 0;
  tracker_reply_t got;
  tracker_reply_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_ready <= 1'b0;
    end else begin
      if (res.valid && sink_ready) begin
        got.outcome       = outcome_e'(res.outcome);
        got.latency_ns    = res.latency_ns;
        got.latency_valid = res.latency_valid;
        got.in_flight     = res.in_flight;
        got.second_index  = res.second_index;
        reply_cnt++;
        if (replies_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result word %0d: outcome %0d",
                                           reply_cnt, got.outcome);
        end else begin
          want = replies_due.pop_front();
          if (got.outcome <= OUT_UNMATCHED) outcome_tally[got.outcome]++;
          if (got.outcome == OUT_MATCHED && !got.latency_valid) early_cnt++;
          if (got.outcome !== want.outcome || got.latency_ns !== want.latency_ns ||
              got.latency_valid !== want.latency_valid ||
              got.in_flight !== want.in_flight ||
              got.second_index !== want.second_index) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("mismatch on word %0d: expected outcome %0d lat %0d/%0b fl %0d sec %0d",
                       reply_cnt, want.outcome, want.latency_ns, want.latency_valid,
                       want.in_flight, want.second_index);
              $display("                      actual outcome %0d lat %0d/%0b fl %0d sec %0d",
                       got.outcome, got.latency_ns, got.latency_valid,
                       got.in_flight, got.second_index);
            end
          end
        end
      end
      if (ready_left == 0) begin
        ready_mode <= 2'($urandom_range(0, 3));
        stall_pat  <= 16'($urandom) | 16'h0001;
        ready_left <= $urandom_range(20, 200);
        sink_ready <= 1'b1;
      end else begin
        ready_left <= ready_left - 1;
        stall_pat  <= {stall_pat[0], stall_pat[15:1]};
        sink_ready <= (ready_mode == 2'd0) || stall_pat[0];
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned idx;
    logic [KEY_W-1:0] s;
    logic [63:0] base_t;

    clock_ns = {32'($urandom_range(0, 3)), $urandom};
    gather_same_bucket(bucket_hash({$urandom, $urandom}), 5);
    for (int b = 0; b < 4; b++) gather_same_bucket(bucket_hash({$urandom, $urandom}), 7);

    base_t = 64'd5000000000;
    queue_word('0, '0, '0);
    queue_word('1, '1, '1);
    queue_word(32'(CODE_ISSUE) | NOTIFY_MASK, 64'd5, 64'd10);
    queue_word(32'(CODE_COMPLETE) | NOTIFY_MASK, 64'd5, 64'd20);
    queue_word(32'd9, 64'd5, 64'd30);
    queue_word(HIGH_BITS | 32'(CODE_ISSUE), '0, '0);
    queue_word(32'(CODE_ISSUE), '1, 64'd1000);
    queue_word(32'(CODE_ISSUE), '0, 64'd5);
    queue_word(HIGH_BITS | 32'(CODE_COMPLETE), '0, '1);
    queue_word(32'(CODE_COMPLETE), '0, 64'd999999999);
    queue_word(32'(CODE_COMPLETE), '1, 64'd500);
    for (int i = 0; i < 5; i++) queue_word(32'(CODE_ISSUE), crowd[i], base_t + i);
    queue_word(32'(CODE_ISSUE), crowd[1], base_t + 10);
    queue_word(32'(CODE_COMPLETE), crowd[2], base_t + 1000000000);
    queue_word(32'(CODE_ISSUE), crowd[4], base_t + 2000000000);
    queue_word(32'(CODE_COMPLETE), crowd[4], base_t + 2000000123);
    queue_word(32'(CODE_COMPLETE), crowd[0], base_t + 3000000000);
    queue_word(32'(CODE_COMPLETE), crowd[1], base_t + 3000000001);
    queue_word(32'(CODE_COMPLETE), crowd[3], base_t + 3000000002);

    while (useful_cnt < 1650) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        if ($urandom_range(0, 1) == 1) queue_word($urandom | NOTIFY_MASK, {$urandom, $urandom},
                                                   next_stamp());
        else queue_word(($urandom & 32'hFFFF_0000) | 32'($urandom_range(9, 65535)),
                        {$urandom, $urandom}, next_stamp());
      end else if (r < 52) begin
        idx = $urandom_range(0, 99);
        if (idx < 45) s = crowd[$urandom_range(0, crowd.size() - 1)];
        else if (idx < 55 && open_sectors.size() != 0)
          s = open_sectors[$urandom_range(0, open_sectors.size() - 1)];
        else s = {$urandom, $urandom};
        open_sectors.push_back(s);
        queue_word(valid_action(CODE_ISSUE), s, next_stamp());
        useful_cnt++;
      end else if (r < 92 && open_sectors.size() != 0) begin
        idx = $urandom_range(0, open_sectors.size() - 1);
        s = open_sectors[idx];
        open_sectors.delete(idx);
        queue_word(valid_action(CODE_COMPLETE), s, next_stamp());
        useful_cnt++;
      end else begin
        s = ($urandom_range(0, 1) == 1) ? crowd[$urandom_range(0, crowd.size() - 1)]
                                        : {$urandom, $urandom};
        queue_word(valid_action(CODE_COMPLETE), s, next_stamp());
        useful_cnt++;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (trace_backlog.size() != 0 || drv_valid) @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d result words: %0d ignored, %0d stored, %0d duplicate,",
             reply_cnt, outcome_tally[OUT_IGNORED], outcome_tally[OUT_STORED],
             outcome_tally[OUT_DUPLICATE]);
    $display("  %0d bucket full, %0d matched (%0d early), %0d unmatched; %0d mismatches",
             outcome_tally[OUT_FULL], outcome_tally[OUT_MATCHED], early_cnt,
             outcome_tally[OUT_UNMATCHED], mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout: %0d result words still due", replies_due.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* pending_io_latency_tracker_unit.f */
rtl/plvt_pkg.sv
rtl/plvt_evt_if.sv
rtl/plvt_res_if.sv
rtl/plvt_sec_div.sv
rtl/pending_io_latency_tracker_unit.sv
verif/testbench.sv
